[sv/rdl_pkg.sv]
`timescale 1ns / 1ps

package rdl_pkg;

  // field widths
  localparam int SAMPLE_W  = 24;
  localparam int FB_W      = 18;
  localparam int BUF_LEN_W = 17;
  localparam int SEG_W     = 16;
  localparam int FADE_W    = 16;
  localparam int GAIN_W    = 17;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;

  // register port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // register reset values
  localparam logic [BUF_LEN_W-1:0] BUF_LEN_RST  = 17'd65536;
  localparam logic [SEG_W-1:0]     SEG_LEN_RST  = 16'd4800;
  localparam logic [FADE_W-1:0]    FADE_LEN_RST = 16'd240;

  // unity gain in q1.16 and rounding offset
  localparam logic [GAIN_W-1:0] FB_ONE     = 17'd65536;
  localparam logic [GAIN_W-1:0] ROUND_HALF = 17'd32768;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [FB_W-1:0]     fb_t;

  typedef enum logic [1:0] {
    REG_BUF_LEN  = 2'd0,
    REG_SEG_LEN  = 2'd1,
    REG_FADE_LEN = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_FADE,
    S_DIV_GAIN,
    S_MOD_START,
    S_DIV_MOD,
    S_READ,
    S_MUL,
    S_ROUND,
    S_MUL_FB,
    S_WRITE
  } state_e;

endpackage

[sv/rdl_in_if.sv]
`timescale 1ns / 1ps

interface rdl_in_if import rdl_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  fb_t     feedback_amount;

  modport source(output valid, sample_in, feedback_amount, input ready);
  modport sink(input valid, sample_in, feedback_amount, output ready);
endinterface

[sv/rdl_out_if.sv]
`timescale 1ns / 1ps

interface rdl_out_if import rdl_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source(output valid, sample_out, input ready);
  modport sink(input valid, sample_out, output ready);
endinterface

[sv/reverse_delay_line.sv]
`timescale 1ns / 1ps

// Mono reverse delay with crossfaded segments.
// Input channel in_i carries one sample and one feedback amount per item;
// output channel out_o returns one reversed, faded sample per item.
// Registers (APB, byte address 4*i): buffer_length, segment_length,
// fade_length; write them only while no item is in flight.
// Each item runs through a sequencer around one shared restoring divider:
// 17 steps for the fade gain, then max(17, log2(DEPTH)) steps for the
// read index wrap, then one sample memory read and two multiplies.
// The result is written to the output register when the item finishes;
// items are handled one at a time, and a new one is taken only after the
// sequencer has returned to wait for it.
// in_i.ready is high only while the sequencer waits for an item.
// A finished result sits in an output register; the next item may be
// taken while it waits, and if out_o is still stalled when that item
// finishes, the sequencer holds in its last step until the output frees.
// After reset the sample store reads as all zeros: a fill mark tracks the
// prefix of entries written so far, so no clearing pass is needed.

module reverse_delay_line import rdl_pkg::*; #(
  parameter int DEPTH       = 65536,
  parameter int MIN_SEGMENT = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rdl_in_if.sink            in_i,
  rdl_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int CW    = (LW > BUF_LEN_W) ? LW : BUF_LEN_W;
  localparam int NW    = (AW > GAIN_W) ? AW : GAIN_W;
  localparam int DVW   = (LW > FADE_W) ? LW : FADE_W;
  localparam int VSW   = NW + 1;
  localparam int CNT_W = $clog2(NW + 1);

  localparam logic [CW-1:0] MIN_SEG_C = CW'(MIN_SEGMENT);
  localparam logic [CW-1:0] LEN_MAX_C = CW'(DEPTH);
  localparam logic [CW-1:0] LEN_MIN_C = CW'(2);

  // configuration registers
  logic [BUF_LEN_W-1:0] buf_len_q;
  logic [SEG_W-1:0]     seg_len_q;
  logic [FADE_W-1:0]    fade_len_q;

  // sequencer and segment state
  state_e            state_q, state_d;
  logic [AW-1:0]     wp_q;
  logic [AW-1:0]     anchor_q;
  logic [SEG_W-1:0]  pos_q;
  logic [SEG_W-1:0]  act_q;
  logic [LW-1:0]     hw_q;

  // item payload
  sample_t           x_q;
  logic [GAIN_W-1:0] fbc_q;
  logic [GAIN_W-1:0] gain_q;
  logic              neg_q;
  logic [AW-1:0]     rd_q;

  // shared divider
  logic [DVW-1:0]    div_r_q;
  logic [NW-1:0]     div_q_q;
  logic [DVW-1:0]    div_d_q;
  logic [CNT_W-1:0]  cnt_q;

  // memory and datapath
  logic [SAMPLE_W-1:0]      mem [DEPTH];
  logic [SAMPLE_W-1:0]      rdata_q;
  logic                     rd_ok_q;
  logic signed [PROD_W-1:0] prod_q;
  sample_t                  rev_q;
  logic signed [PROD_W-1:0] fbprod_q;

  // output register
  logic    out_valid_q;
  sample_t out_data_q;

  // register port
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q  <= BUF_LEN_RST;
      seg_len_q  <= SEG_LEN_RST;
      fade_len_q <= FADE_LEN_RST;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[APB_AW-1:2]))
        REG_BUF_LEN:  buf_len_q  <= pwdata[BUF_LEN_W-1:0];
        REG_SEG_LEN:  seg_len_q  <= pwdata[SEG_W-1:0];
        REG_FADE_LEN: fade_len_q <= pwdata[FADE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[APB_AW-1:2]))
      REG_BUF_LEN:  prdata = APB_DW'(buf_len_q);
      REG_SEG_LEN:  prdata = APB_DW'(seg_len_q);
      REG_FADE_LEN: prdata = APB_DW'(fade_len_q);
      default:      prdata = '0;
    endcase
  end

  // effective buffer length, clamped to [2, DEPTH]
  logic [CW-1:0] buf_ext;
  logic [LW-1:0] len;
  assign buf_ext = CW'(buf_len_q);
  always_comb begin
    if (buf_ext < LEN_MIN_C) begin
      len = LW'(LEN_MIN_C);
    end else if (buf_ext > LEN_MAX_C) begin
      len = LW'(LEN_MAX_C);
    end else begin
      len = LW'(buf_ext);
    end
  end

  // segment length for a new segment
  logic [CW-1:0]    seg_req;
  logic [CW-1:0]    seg_half;
  logic [SEG_W-1:0] seg_new;
  logic [AW-1:0]    wp_eff;
  always_comb begin
    seg_req  = (CW'(seg_len_q) < MIN_SEG_C) ? MIN_SEG_C : CW'(seg_len_q);
    seg_half = CW'(len >> 1);
    seg_new  = (seg_req > seg_half) ? SEG_W'(seg_half) : SEG_W'(seg_req);
    wp_eff   = (LW'(wp_q) >= len) ? '0 : wp_q;
  end

  // fade length and gain numerator
  logic [SEG_W-1:0] quarter;
  logic [SEG_W-1:0] fade_m;
  logic [SEG_W-1:0] fade;
  logic [SEG_W-1:0] remain;
  logic [SEG_W-1:0] num;
  always_comb begin
    quarter = act_q >> 2;
    fade_m  = (fade_len_q < quarter) ? fade_len_q : quarter;
    fade    = (fade_m == '0) ? SEG_W'(1) : fade_m;
    remain  = act_q - pos_q;
    if (pos_q < fade) begin
      num = pos_q;
    end else if (remain < fade) begin
      num = remain;
    end else begin
      num = fade;
    end
  end

  // signed read offset before wrapping
  logic [VSW-1:0] voff;
  logic [NW-1:0]  vmag;
  assign voff = VSW'(anchor_q) - VSW'(1) - VSW'(pos_q);
  assign vmag = voff[VSW-1] ? NW'(VSW'(0) - voff) : NW'(voff);

  // one restoring divider step
  logic [DVW+1:0] trial;
  logic           ge;
  logic [DVW-1:0] r_step;
  logic [NW-1:0]  q_step;
  always_comb begin
    trial  = {1'b0, div_r_q, div_q_q[NW-1]} - {2'b00, div_d_q};
    ge     = ~trial[DVW+1];
    r_step = ge ? trial[DVW-1:0] : {div_r_q[DVW-2:0], div_q_q[NW-1]};
    q_step = {div_q_q[NW-2:0], ge};
  end

  // wrapped read index from remainder
  logic [AW-1:0] rd_idx;
  assign rd_idx = (neg_q && div_r_q != '0) ? AW'(len - LW'(div_r_q)) : AW'(div_r_q);

  // write value: input plus rounded feedback, saturated
  logic signed [PROD_W-1:0] fb_rnd;
  sample_t                  fbp;
  logic signed [SAMPLE_W:0] wsum;
  sample_t                  wval;
  logic signed [PROD_W-1:0] rev_rnd;
  sample_t                  stored;
  always_comb begin
    stored  = rd_ok_q ? sample_t'(rdata_q) : '0;
    rev_rnd = prod_q + PROD_W'(ROUND_HALF);
    fb_rnd  = fbprod_q + PROD_W'(ROUND_HALF);
    fbp     = fb_rnd[FRAC_W +: SAMPLE_W];
    wsum    = {x_q[SAMPLE_W-1], x_q} + {fbp[SAMPLE_W-1], fbp};
    if (wsum[SAMPLE_W] != wsum[SAMPLE_W-1]) begin
      wval = wsum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      wval = wsum[SAMPLE_W-1:0];
    end
  end

  // pointer updates at the end of an item
  logic [LW-1:0] wp_inc;
  logic [AW-1:0] wp_next;
  logic [LW-1:0] hw_next;
  always_comb begin
    wp_inc  = LW'(wp_q) + LW'(1);
    wp_next = (wp_inc >= len) ? '0 : AW'(wp_inc);
    hw_next = (wp_inc > hw_q) ? wp_inc : hw_q;
  end

  logic out_free;
  logic in_acc;
  logic finish;
  assign out_free = ~out_valid_q | out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc   = in_i.valid & in_i.ready;
  assign finish   = (state_q == S_WRITE) & out_free;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (in_acc) state_d = S_PREP;
      S_PREP:      state_d = S_FADE;
      S_FADE:      state_d = S_DIV_GAIN;
      S_DIV_GAIN:  if (cnt_q == '0) state_d = S_MOD_START;
      S_MOD_START: state_d = S_DIV_MOD;
      S_DIV_MOD:   if (cnt_q == '0) state_d = S_READ;
      S_READ:      state_d = S_MUL;
      S_MUL:       state_d = S_ROUND;
      S_ROUND:     state_d = S_MUL_FB;
      S_MUL_FB:    state_d = S_WRITE;
      S_WRITE:     if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // segment state and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      anchor_q <= '0;
      pos_q    <= '0;
      act_q    <= '0;
      hw_q     <= '0;
    end else if (state_q == S_PREP) begin
      wp_q <= wp_eff;
      if (pos_q >= act_q) begin
        act_q    <= seg_new;
        pos_q    <= '0;
        anchor_q <= wp_eff;
      end
    end else if (finish) begin
      wp_q  <= wp_next;
      pos_q <= pos_q + SEG_W'(1);
      hw_q  <= hw_next;
    end
  end

  // divider step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q == S_FADE) begin
      cnt_q <= CNT_W'(GAIN_W);
    end else if (state_q == S_MOD_START) begin
      cnt_q <= CNT_W'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // item payload and divider datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_i.sample_in;
      if (in_i.feedback_amount < 0) begin
        fbc_q <= '0;
      end else if (in_i.feedback_amount > fb_t'(FB_ONE)) begin
        fbc_q <= FB_ONE;
      end else begin
        fbc_q <= GAIN_W'(in_i.feedback_amount);
      end
    end
    case (state_q)
      S_FADE: begin
        // gain = num * 2^16 / fade, first bits preloaded into the remainder
        div_r_q <= DVW'(num >> 1);
        div_q_q <= NW'({num[0], {FRAC_W{1'b0}}}) << (NW - GAIN_W);
        div_d_q <= DVW'(fade);
      end
      S_DIV_GAIN: begin
        if (cnt_q != '0) begin
          div_r_q <= r_step;
          div_q_q <= q_step;
        end else begin
          gain_q <= div_q_q[GAIN_W-1:0];
        end
      end
      S_MOD_START: begin
        // read offset modulo buffer length
        div_r_q <= '0;
        div_q_q <= vmag;
        div_d_q <= DVW'(len);
        neg_q   <= voff[VSW-1];
      end
      S_DIV_MOD: begin
        if (cnt_q != '0) begin
          div_r_q <= r_step;
          div_q_q <= q_step;
        end else begin
          rd_q <= rd_idx;
        end
      end
      S_MUL:    prod_q   <= PROD_W'(stored) * PROD_W'($signed({1'b0, gain_q}));
      S_ROUND:  rev_q    <= rev_rnd[FRAC_W +: SAMPLE_W];
      S_MUL_FB: fbprod_q <= PROD_W'(rev_q) * PROD_W'($signed({1'b0, fbc_q}));
      default: ;
    endcase
  end

  // sample store: entries below the fill mark hold written data
  always_ff @(posedge clk_i) begin
    if (finish) begin
      mem[wp_q] <= wval;
    end
    if (state_q == S_READ) begin
      rdata_q <= mem[rd_q];
      rd_ok_q <= (LW'(rd_q) < hw_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q <= rev_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  // checks
  a_pos_in_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= act_q)
    else $error("segment position beyond active segment length");

  a_wp_below_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(wp_q) <= hw_q)
    else $error("write pointer ahead of fill mark");

  a_fill_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> hw_q >= $past(hw_q))
    else $error("fill mark decreased");

  a_out_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_WRITE))
    else $error("result shown without finishing an item");

endmodule
